// ===== rtl/sqmm_pkg.sv =====
// sqmm_pkg: shared types and constants for the square matrix multiply core.
// No dependencies; every other rtl file except sqmm_ram imports it.
package sqmm_pkg;

    localparam int MATRIX_SIZE_DEF   = 4;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH       = 2;

    localparam int IDX_W = 4;
    localparam int VAL_W = 32;
    localparam int PROD_W = 2 * VAL_W;

    typedef enum logic [1:0] {
        OP_WR_A = 2'd0,
        OP_WR_B = 2'd1,
        OP_MUL  = 2'd2
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  index;
        logic [VAL_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

endpackage

// ===== rtl/sqmm_ram.sv =====
// sqmm_ram: generic simple dual-port RAM, one write port, one registered read port.
// Depends on nothing.
module sqmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sqmm_front.sv =====
// sqmm_front: input handshake; sorts incoming transactions and drops ones with no effect.
// Depends on sqmm_pkg.
module sqmm_front import sqmm_pkg::*; #(
    parameter int MATRIX_SIZE = MATRIX_SIZE_DEF
) (
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [1:0]       i_op,
    input  logic [IDX_W-1:0] i_element_index,
    input  logic [VAL_W-1:0] i_element_value,
    input  t_q_status        i_q_status,
    output logic             o_push,
    output t_cmd             o_cmd
);

    localparam int ELEMENTS = MATRIX_SIZE * MATRIX_SIZE;

    logic is_write;
    logic in_range;
    logic keep;

    always_comb begin
        is_write = i_op inside {OP_WR_A, OP_WR_B};
        in_range = 32'(i_element_index) < 32'(ELEMENTS);
        // out-of-range writes and the unused op code are accepted and discarded
        keep     = (i_op == OP_MUL) || (is_write && in_range);
        o_stall  = i_q_status.full;
        o_push   = i_valid && !i_q_status.full && keep;
        o_cmd.op    = t_op'(i_op);
        o_cmd.index = i_element_index;
        o_cmd.value = i_element_value;
    end

endmodule

// ===== rtl/sqmm_queue.sv =====
// sqmm_queue: short command FIFO between the front and the execution engine.
// Depends on sqmm_pkg.
module sqmm_queue import sqmm_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_entry [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push, do_pop;

    always_comb begin
        o_status.empty = (r_count == '0);
        o_status.full  = (r_count == CNT_W'(DEPTH));
        do_push = i_push && !o_status.full;
        do_pop  = i_pop && !o_status.empty;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
        o_head = r_entry[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/sqmm_back.sv =====
// sqmm_back: execution engine; matrix stores, multiply-accumulate pipeline, output register.
// Depends on sqmm_pkg and sqmm_ram.
module sqmm_back import sqmm_pkg::*; #(
    parameter int MATRIX_SIZE   = MATRIX_SIZE_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_head,
    input  t_q_status        i_q_status,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [IDX_W-1:0] o_product_index,
    output logic [VAL_W-1:0] o_product_value,
    output logic             o_last
);

    localparam int ELEMENTS = MATRIX_SIZE * MATRIX_SIZE;
    localparam int ADDR_W   = $clog2(ELEMENTS);
    localparam int CNT_W    = $clog2(MATRIX_SIZE);
    localparam int ACC_W    = PROD_W + $clog2(MATRIX_SIZE);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_x, n_x;
    logic [CNT_W-1:0]    r_y, n_y;
    logic [CNT_W-1:0]    r_i, n_i;
    logic                r_rd_vld, r_rd_first;
    logic                r_mul_vld, r_mul_first;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                r_out_valid;
    logic [IDX_W-1:0]    r_out_index;
    logic [VAL_W-1:0]    r_out_value;
    logic                r_out_last;

    logic                we_a, we_b;
    logic [ADDR_W-1:0]   waddr;
    logic [ADDR_W-1:0]   raddr_a, raddr_b;
    logic [VAL_W-1:0]    rdata_a, rdata_b;
    logic signed [VAL_W-1:0] op_a, op_b;
    logic signed [ACC_W-1:0] shifted;
    logic                fits;
    logic [VAL_W-1:0]    sat_value;
    logic                last_elem;
    logic                load;
    logic [31:0]         elem_k;

    assign waddr   = ADDR_W'(i_head.index);
    assign raddr_a = ADDR_W'(32'(r_x) + 32'(MATRIX_SIZE) * 32'(r_i));
    assign raddr_b = ADDR_W'(32'(r_i) + 32'(MATRIX_SIZE) * 32'(r_y));

    sqmm_ram #(.WIDTH(VAL_W), .DEPTH(ELEMENTS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (i_head.value),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    sqmm_ram #(.WIDTH(VAL_W), .DEPTH(ELEMENTS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (i_head.value),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    assign op_a = rdata_a;
    assign op_b = rdata_b;

    // floor shift, then saturate if the bits above 32 are not all sign copies
    always_comb begin
        shifted   = r_acc >>> FRACTION_BITS;
        fits      = (&shifted[ACC_W-1:VAL_W-1]) || !(|shifted[ACC_W-1:VAL_W-1]);
        sat_value = fits ? shifted[VAL_W-1:0]
                  : (shifted[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                      : {1'b0, {(VAL_W-1){1'b1}}});
        last_elem = (r_x == CNT_W'(MATRIX_SIZE - 1)) && (r_y == CNT_W'(MATRIX_SIZE - 1));
        elem_k    = 32'(r_x) + 32'(MATRIX_SIZE) * 32'(r_y);
    end

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_i     = r_i;
        o_pop   = 1'b0;
        we_a    = 1'b0;
        we_b    = 1'b0;
        load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop = 1'b1;
                    we_a  = (i_head.op == OP_WR_A);
                    we_b  = (i_head.op == OP_WR_B);
                    if (i_head.op == OP_MUL) begin
                        n_x     = '0;
                        n_y     = '0;
                        n_i     = '0;
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (r_i == CNT_W'(MATRIX_SIZE - 1)) begin
                    n_i     = '0;
                    n_state = ST_DRAIN;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            ST_DRAIN: begin
                // wait for the last product to land and the output slot to free up
                if (!r_rd_vld && !r_mul_vld && (!r_out_valid || !i_stall)) begin
                    load = 1'b1;
                    if (last_elem) begin
                        n_state = ST_IDLE;
                    end else begin
                        if (r_x == CNT_W'(MATRIX_SIZE - 1)) begin
                            n_x = '0;
                            n_y = r_y + 1'b1;
                        end else begin
                            n_x = r_x + 1'b1;
                        end
                        n_state = ST_RUN;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_x         <= '0;
            r_y         <= '0;
            r_i         <= '0;
            r_rd_vld    <= 1'b0;
            r_mul_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_x       <= n_x;
            r_y       <= n_y;
            r_i       <= n_i;
            r_rd_vld  <= (r_state == ST_RUN);
            r_mul_vld <= r_rd_vld;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_first  <= (r_i == '0);
        r_mul_first <= r_rd_first;
        r_prod      <= op_a * op_b;
        if (r_mul_vld) begin
            r_acc <= r_mul_first ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
        if (load) begin
            r_out_index <= elem_k[IDX_W-1:0];
            r_out_value <= sat_value;
            r_out_last  <= last_elem;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_product_index = r_out_index;
    assign o_product_value = r_out_value;
    assign o_last          = r_out_last;

endmodule

// ===== rtl/square_matrix_multiply_core.sv =====
// Square matrix multiply core, signed fixed point, column-major A*B.
// Element loads pass through a two-entry command queue; op 3 and
// out-of-range writes are taken and dropped. A compute walks MATRIX_SIZE reads of each
// store per element, then drains the read, multiply and accumulate registers and loads
// the output register, which holds while i_stall is high, before the next element starts.
// Reset (i_rst_n low, synchronous) empties the queue and output; the stores are not cleared.
module square_matrix_multiply_core import sqmm_pkg::*; #(
    parameter int MATRIX_SIZE   = MATRIX_SIZE_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [1:0]       i_op,
    input  logic [IDX_W-1:0] i_element_index,
    input  logic [VAL_W-1:0] i_element_value,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [IDX_W-1:0] o_product_index,
    output logic [VAL_W-1:0] o_product_value,
    output logic             o_last
);

    logic      push, pop;
    t_cmd      push_cmd, head;
    t_q_status q_status;

    sqmm_front #(.MATRIX_SIZE(MATRIX_SIZE)) u_front (
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_element_index (i_element_index),
        .i_element_value (i_element_value),
        .i_q_status      (q_status),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    sqmm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    sqmm_back #(
        .MATRIX_SIZE   (MATRIX_SIZE),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_q_status      (q_status),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_product_index (o_product_index),
        .o_product_value (o_product_value),
        .o_last          (o_last)
    );

endmodule

// ===== rtl/sqmm_checker.sv =====
// sqmm_checker: port-level assertions for the matrix multiply core, bound to the top.
// Depends on sqmm_pkg and square_matrix_multiply_core.
module sqmm_checker import sqmm_pkg::*; #(
    parameter int MATRIX_SIZE = MATRIX_SIZE_DEF
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_stall,
    input logic [IDX_W-1:0] o_product_index,
    input logic [VAL_W-1:0] o_product_value,
    input logic             o_last
);

    localparam int ELEMENTS = MATRIX_SIZE * MATRIX_SIZE;
    localparam int EXP_W    = $clog2(ELEMENTS);

    logic [EXP_W-1:0] r_exp;

    // expected position of the next result transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= '0;
        end else if (o_valid && !i_stall) begin
            r_exp <= (r_exp == EXP_W'(ELEMENTS - 1)) ? '0 : r_exp + 1'b1;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_product_value))
        else $error("stalled result changed");

    a_index_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_product_index == IDX_W'(r_exp))
        else $error("product index out of order");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_last == (r_exp == EXP_W'(ELEMENTS - 1)))
        else $error("last flag on wrong element");

endmodule

bind square_matrix_multiply_core sqmm_checker #(.MATRIX_SIZE(MATRIX_SIZE)) u_sqmm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_product_index (o_product_index),
    .o_product_value (o_product_value),
    .o_last          (o_last)
);
